// ----- sv/rmm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants for the row median / mean collapse block.
// ----------------------------------------------------------------------------
package rmm_pkg;

    // Pixel and row number widths
    localparam int PIX_W = 32;
    localparam int ROW_W = 16;

    // Default depth of the sorting chain
    localparam int MAX_ROW_DEF = 256;

    // Configuration register indexes
    localparam logic REG_STAT_MODE = 1'b0;
    localparam logic REG_FIRST_ROW = 1'b1;

    // Statistic selection
    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DIV
    } t_state;

    // Control handed to every cell of the chain
    typedef struct packed {
        logic ins;
        logic shl;
    } t_cell_ctl;

endpackage

// ----- sv/rmm_cell.sv -----
// ----------------------------------------------------------------------------
// rmm_cell
// One cell of the insertion-sort chain: holds one pixel, makes room for a new
// item by taking its left neighbor's value, or shifts left on drain.
// ----------------------------------------------------------------------------
module rmm_cell (
    input  logic                                  i_clk,
    input  rmm_pkg::t_cell_ctl                    i_ctl,
    input  logic                                  i_occ,
    input  logic signed [rmm_pkg::PIX_W-1:0]      i_new,
    input  logic signed [rmm_pkg::PIX_W-1:0]      i_left_val,
    input  logic                                  i_left_gt,
    input  logic signed [rmm_pkg::PIX_W-1:0]      i_right_val,
    output logic signed [rmm_pkg::PIX_W-1:0]      o_val,
    output logic                                  o_gt
);

    logic signed [rmm_pkg::PIX_W-1:0] r_val;

    // An empty cell counts as larger than any pixel
    assign o_gt  = !i_occ || (r_val > i_new);
    assign o_val = r_val;

    // Insert or shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && o_gt) begin
            r_val <= i_left_gt ? i_left_val : i_new;
        end else if (i_ctl.shl) begin
            r_val <= i_right_val;
        end
    end

endmodule

// ----- sv/rmm_divider.sv -----
// ----------------------------------------------------------------------------
// rmm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmm_divider #(
    parameter int SW = rmm_pkg::PIX_W + $clog2(rmm_pkg::MAX_ROW_DEF),
    parameter int CW = $clog2(rmm_pkg::MAX_ROW_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_quotient
);

    localparam int KW = $clog2(SW + 1);

    logic [CW-1:0] r_rem;
    logic [SW-1:0] r_q;
    logic [CW-1:0] r_d;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [CW:0]   w_t;
    logic [CW:0]   w_diff;
    logic          w_ge;

    assign w_t    = {r_rem, r_q[SW-1]};
    assign w_diff = w_t - {1'b0, r_d};
    assign w_ge   = w_t >= {1'b0, r_d};

    // Load and iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_t[CW-1:0];
            r_q   <= {r_q[SW-2:0], w_ge};
        end
    end

    // Step count and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == KW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- sv/row_median_mean_collapse.sv -----
// ----------------------------------------------------------------------------
// row_median_mean_collapse
// Per-row median or mean of finite pixels, kept sorted in a cell chain.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low; each finite pixel is
// inserted into a sorted chain of MAX_ROW cells in that same cycle while the
// chain holds fewer than MAX_ROW pixels, else it is dropped. The pixel that
// ends a row raises busy: in median mode the chain shifts left once a cycle
// until the middle values reach its head; in mean mode an iterative divider
// takes one quotient bit a cycle. An empty row needs no shift and no division.
// The result appears for exactly one cycle with o_done high; the receiver
// cannot stall it, so it must take every result as it comes.
module row_median_mean_collapse #(
    parameter int MAX_ROW = rmm_pkg::MAX_ROW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rmm_pkg::PIX_W-1:0]  i_pixel,
    input  logic                              i_finite,
    input  logic                              i_row_end,
    // result side
    output logic                              o_done,
    output logic [rmm_pkg::ROW_W-1:0]         o_row_number,
    output logic signed [rmm_pkg::PIX_W-1:0]  o_statistic,
    output logic                              o_empty_row,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int PW = rmm_pkg::PIX_W;
    localparam int RW = rmm_pkg::ROW_W;
    localparam int CW = $clog2(MAX_ROW + 1);
    localparam int SW = PW + $clog2(MAX_ROW);

    // Configuration registers
    logic          r_mode;
    logic [RW-1:0] r_first_row;

    // Row state
    logic [CW-1:0]        r_count;
    logic signed [SW-1:0] r_sum;
    logic [RW-1:0]        r_rows_done;

    // Sequencer
    rmm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_steps;
    logic            r_odd;
    logic            r_neg;
    logic            r_empty;
    logic [RW-1:0]   r_row_num;

    // Result registers
    logic             r_done, n_done;
    logic signed [PW-1:0] r_stat, n_stat;
    logic             r_empty_out, n_empty_out;
    logic [RW-1:0]    r_row_out, n_row_out;

    // Item datapath
    logic                 w_accept;
    logic                 w_add;
    logic [CW-1:0]        w_count_nx;
    logic signed [SW-1:0] w_sum_nx;
    logic [SW-1:0]        w_sum_mag;
    logic [CW-1:0]        w_half;
    logic                 w_cfg_wr;

    // Chain wiring
    rmm_pkg::t_cell_ctl w_ctl;
    logic signed [PW-1:0] w_val [MAX_ROW];
    logic                 w_gt  [MAX_ROW];

    // Divider
    logic          w_div_start;
    logic          w_div_done;
    logic [SW-1:0] w_quot;
    logic signed [SW-1:0] w_mean;
    logic signed [PW:0]   w_pair;

    assign busy     = (r_state != rmm_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_add    = i_finite && (r_count < CW'(MAX_ROW));
    assign w_count_nx = r_count + CW'(w_add);
    assign w_sum_nx   = r_sum + (w_add ? SW'(i_pixel) : SW'(0));
    assign w_sum_mag  = w_sum_nx[SW-1] ? SW'(-w_sum_nx) : SW'(w_sum_nx);
    assign w_half     = w_count_nx >> 1;

    assign w_ctl.ins = w_accept && w_add;
    assign w_ctl.shl = (r_state == rmm_pkg::ST_SHIFT) && (r_steps != '0);

    // Build the chain
    for (genvar g = 0; g < MAX_ROW; g++) begin : g_cell
        logic signed [PW-1:0] w_lv;
        logic                 w_lg;
        logic signed [PW-1:0] w_rv;
        if (g == 0) begin : g_head
            assign w_lv = '0;
            assign w_lg = 1'b0;
        end else begin : g_body
            assign w_lv = w_val[g-1];
            assign w_lg = w_gt[g-1];
        end
        if (g == MAX_ROW - 1) begin : g_tail
            assign w_rv = '0;
        end else begin : g_mid
            assign w_rv = w_val[g+1];
        end
        rmm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CW'(g) < r_count),
            .i_new       (i_pixel),
            .i_left_val  (w_lv),
            .i_left_gt   (w_lg),
            .i_right_val (w_rv),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    // Mean divider
    assign w_div_start = w_accept && i_row_end && (r_mode == rmm_pkg::MODE_MEAN)
                         && (w_count_nx != '0);

    rmm_divider #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_mag),
        .i_divisor  (w_count_nx),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_mean = r_neg ? SW'(-w_quot) : SW'(w_quot);
    assign w_pair = (PW + 1)'(w_val[0]) + (PW + 1)'(w_val[1]);

    // Configuration writes
    assign w_cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rmm_pkg::MODE_MEDIAN;
            r_first_row <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                rmm_pkg::REG_STAT_MODE: r_mode      <= pwdata[0];
                rmm_pkg::REG_FIRST_ROW: r_first_row <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            rmm_pkg::REG_STAT_MODE: prdata = {31'd0, r_mode};
            rmm_pkg::REG_FIRST_ROW: prdata = {16'd0, r_first_row};
            default:                prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Row accumulation and row-end capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_rows_done <= '0;
        end else if (w_accept) begin
            if (i_row_end) begin
                r_count     <= '0;
                r_sum       <= '0;
                r_rows_done <= r_rows_done + 1'b1;
            end else begin
                r_count <= w_count_nx;
                r_sum   <= w_sum_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (w_accept && i_row_end) begin
            if (w_count_nx == '0) begin
                r_steps <= '0;
            end else if (w_count_nx[0]) begin
                r_steps <= w_half;
            end else begin
                r_steps <= w_half - 1'b1;
            end
        end else if (w_ctl.shl) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_row_end) begin
            r_odd     <= w_count_nx[0];
            r_neg     <= w_sum_nx[SW-1];
            r_empty   <= (w_count_nx == '0);
            r_row_num <= r_first_row + r_rows_done;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmm_pkg::ST_IDLE: begin
                if (w_accept && i_row_end) begin
                    n_state = w_div_start ? rmm_pkg::ST_DIV : rmm_pkg::ST_SHIFT;
                end
            end
            rmm_pkg::ST_SHIFT: begin
                if (r_steps == '0) begin
                    n_state = rmm_pkg::ST_IDLE;
                end
            end
            rmm_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = rmm_pkg::ST_IDLE;
                end
            end
            default: n_state = rmm_pkg::ST_IDLE;
        endcase
    end

    // Result outputs
    always_comb begin
        n_done      = 1'b0;
        n_stat      = r_stat;
        n_empty_out = r_empty_out;
        n_row_out   = r_row_out;
        case (r_state)
            rmm_pkg::ST_SHIFT: begin
                if (r_steps == '0) begin
                    n_done      = 1'b1;
                    n_row_out   = r_row_num;
                    n_empty_out = r_empty;
                    if (r_empty) begin
                        n_stat = '0;
                    end else if (r_odd) begin
                        n_stat = w_val[0];
                    end else begin
                        n_stat = w_pair[PW:1];
                    end
                end
            end
            rmm_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_done      = 1'b1;
                    n_row_out   = r_row_num;
                    n_empty_out = 1'b0;
                    n_stat      = w_mean[PW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmm_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat      <= n_stat;
        r_empty_out <= n_empty_out;
        r_row_out   <= n_row_out;
    end

    assign o_done       = r_done;
    assign o_row_number = r_row_out;
    assign o_statistic  = r_stat;
    assign o_empty_row  = r_empty_out;

endmodule

// ----- bench/tb_row_median_mean_collapse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_median_mean_collapse
// Self-checking bench for the row median / mean collapse block.
// ----------------------------------------------------------------------------
// Streams pixel items through the command port and predicts each row result
// with a behavioral sorted store and running sum. Every result strobe is
// compared field by field against the oldest predicted row. Covers median and
// mean modes, empty rows, skipped row ends, a full store and row number wrap,
// with random sender gaps.
// ----------------------------------------------------------------------------
module tb_row_median_mean_collapse;

    localparam int MAX_ROW     = rmm_pkg::MAX_ROW_DEF;
    localparam int DRAIN_WAIT  = 60;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [rmm_pkg::ROW_W-1:0]        row;
        logic signed [rmm_pkg::PIX_W-1:0] stat;
        logic                             empty;
    } t_row_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic signed [rmm_pkg::PIX_W-1:0] i_pixel = '0;
    logic                             i_finite = 1'b0;
    logic                             i_row_end = 1'b0;
    logic                             o_done;
    logic [rmm_pkg::ROW_W-1:0]        o_row_number;
    logic signed [rmm_pkg::PIX_W-1:0] o_statistic;
    logic                             o_empty_row;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [2:0]                       paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    // Predictor state
    logic                             mode_q = rmm_pkg::MODE_MEDIAN;
    logic [rmm_pkg::ROW_W-1:0]        first_row_q = '0;
    logic [rmm_pkg::ROW_W-1:0]        rows_done_q = '0;
    int                               sorted_pix[$];
    longint                           pix_sum = 0;
    t_row_result                      pending_rows[$];

    int  mismatches = 0;
    int  rows_checked = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  gaps_on = 1'b1;

    row_median_mean_collapse #(.MAX_ROW(MAX_ROW)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Take in one pixel; queue a row result on row end
    task automatic predict_pixel(input logic signed [rmm_pkg::PIX_W-1:0] pix,
                                 input logic fin, input logic last);
        t_row_result r;
        int pos;
        int n;
        longint pair;
        if (fin && sorted_pix.size() < MAX_ROW) begin
            pos = 0;
            while (pos < sorted_pix.size() && sorted_pix[pos] <= pix) pos++;
            sorted_pix.insert(pos, pix);
            pix_sum += pix;
        end
        if (last) begin
            n = sorted_pix.size();
            r.row = first_row_q + rows_done_q;
            r.empty = (n == 0);
            if (n == 0) begin
                r.stat = '0;
            end else if (mode_q == rmm_pkg::MODE_MEAN) begin
                r.stat = rmm_pkg::PIX_W'(pix_sum / n);
            end else if (n % 2 == 1) begin
                r.stat = sorted_pix[n / 2];
            end else begin
                pair = longint'(sorted_pix[n / 2]) + longint'(sorted_pix[n / 2 - 1]);
                r.stat = rmm_pkg::PIX_W'(pair >>> 1);
            end
            pending_rows.push_back(r);
            rows_done_q++;
            sorted_pix.delete();
            pix_sum = 0;
        end
    endtask

    // Present one item, hold until accepted, then maybe idle
    task automatic send_pixel(input logic signed [rmm_pkg::PIX_W-1:0] pix,
                              input logic fin, input logic last);
        start <= 1'b1;
        i_pixel <= pix;
        i_finite <= fin;
        i_row_end <= last;
        do @(posedge i_clk); while (busy);
        predict_pixel(pix, fin, last);
        items_sent++;
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every predicted row
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == rmm_pkg::REG_STAT_MODE) mode_q = val[0];
        else first_row_q = val[rmm_pkg::ROW_W-1:0];
    endtask

    function automatic logic signed [rmm_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 15) - 8) <<< 16;
        endcase
    endfunction

    // Extremes, both modes, empty and skipped row ends, odd and even counts
    task automatic test_directed;
        logic md;
        for (int m = 0; m < 2; m++) begin
            md = (m == 0) ? rmm_pkg::MODE_MEDIAN : rmm_pkg::MODE_MEAN;
            write_reg(rmm_pkg::REG_STAT_MODE, {31'd0, md});
            send_pixel(32'sh7FFF_FFFF, 1'b1, 1'b0);
            send_pixel(32'sh8000_0000, 1'b1, 1'b1);
            send_pixel(32'sh0001_0000, 1'b0, 1'b1);
            send_pixel(32'sh0003_0000, 1'b1, 1'b0);
            send_pixel(-32'sh0001_0000, 1'b1, 1'b0);
            send_pixel(32'sh0000_0001, 1'b0, 1'b0);
            send_pixel(32'sh7FFF_FFFF, 1'b1, 1'b1);
            send_pixel(-32'sh0000_0003, 1'b1, 1'b1);
            send_pixel(32'sh0000_0002, 1'b1, 1'b0);
            send_pixel(-32'sh0000_0005, 1'b1, 1'b1);
            drain();
        end
    endtask

    // Row number wraps past the top of its range
    task automatic test_row_wrap;
        logic [rmm_pkg::ROW_W-1:0] base;
        base = 16'hFFFE - rows_done_q;
        write_reg(rmm_pkg::REG_FIRST_ROW, {16'd0, base});
        repeat (4) send_pixel(rand_pixel(), 1'b1, 1'b1);
        drain();
        write_reg(rmm_pkg::REG_FIRST_ROW, 32'h0000_0000);
    endtask

    // Overfill one row in mean mode; extra finite pixels are dropped
    task automatic test_full_row;
        write_reg(rmm_pkg::REG_STAT_MODE, {31'd0, rmm_pkg::MODE_MEAN});
        for (int k = 0; k < MAX_ROW + 4; k++)
            send_pixel(k >= MAX_ROW ? 32'sh7FFF_FFFF : rand_pixel(), 1'b1,
                       k == MAX_ROW + 3);
        drain();
    endtask

    // Random rows, mostly short and well formed, some empty
    task automatic test_random(input int n_items, input logic mode,
                               input logic [15:0] base_row);
        int len;
        int sent;
        write_reg(rmm_pkg::REG_STAT_MODE, {31'd0, mode});
        write_reg(rmm_pkg::REG_FIRST_ROW, {16'd0, base_row});
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                send_pixel(rand_pixel(), $urandom_range(0, 99) < 80, k == len - 1);
            sent += len;
        end
        drain();
    endtask

    // Compare every result strobe with the oldest predicted row
    always @(posedge i_clk) begin
        t_row_result want;
        if ((start && !busy) || o_done || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_done) begin
            rows_checked++;
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row result: row %0d stat %0d empty %0b",
                             o_row_number, o_statistic, o_empty_row);
            end else begin
                want = pending_rows.pop_front();
                if (o_row_number !== want.row || o_statistic !== want.stat ||
                    o_empty_row !== want.empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"row mismatch: expected row %0d stat %0d empty %0b,",
                                  " got row %0d stat %0d empty %0b"},
                                 want.row, want.stat, want.empty,
                                 o_row_number, o_statistic, o_empty_row);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_row_wrap();
        test_full_row();
        test_random(55, rmm_pkg::MODE_MEDIAN, 16'h0010);
        gaps_on = 1'b0;
        test_random(55, rmm_pkg::MODE_MEAN, 16'h8000);
        gaps_on = 1'b1;
        test_random(55, rmm_pkg::MODE_MEDIAN, 16'hFFF0);
        drain();
        $display("sent %0d pixel items, checked %0d row results", items_sent, rows_checked);
        $display("modes median and mean, empty rows, a full row, row number wrap");
        if (mismatches == 0 && pending_rows.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rmm_pkg.sv
sv/rmm_cell.sv
sv/rmm_divider.sv
sv/row_median_mean_collapse.sv
bench/tb_row_median_mean_collapse.sv
